// ----- design/hnsc_pkg.sv -----
// shared types, constants and lookups for the host name syntax checker
package hnsc_pkg;

  localparam int MAX_LABEL_LENGTH = 63;
  localparam int LH_LEN           = 9;
  localparam int QUAD_MAX_VALUE   = 255;
  localparam int QUAD_MAX_DIGITS  = 3;
  localparam int QUAD_SEGMENTS    = 4;
  localparam int SEG_COUNT_MAX    = 7;
  localparam int LABEL_COUNT_MAX  = 3;

  typedef enum logic [1:0] {
    KIND_REJECT    = 2'd0,
    KIND_LOCALHOST = 2'd1,
    KIND_QUAD      = 2'd2,
    KIND_DOMAIN    = 2'd3
  } host_kind_t;

  typedef struct packed {
    logic       seen_any_char;
    logic       only_digit_dot_hyphen;
    logic       has_hyphen;
    logic [3:0] localhost_match_pos;
    logic       localhost_mismatch;
    logic [2:0] quad_segment_count;
    logic [2:0] quad_segment_length;
    logic [9:0] quad_segment_value;
    logic       quad_leading_zero;
    logic       quad_error;
    logic [6:0] label_length;
    logic [1:0] label_dots;
    logic       prev_was_dot;
    logic       prev_was_hyphen;
    logic       first_was_dot;
    logic       domain_error;
  } hnsc_state_t;

  localparam hnsc_state_t STATE_INIT = '{
    seen_any_char:         1'b0,
    only_digit_dot_hyphen: 1'b1,
    has_hyphen:            1'b0,
    localhost_match_pos:   4'd0,
    localhost_mismatch:    1'b0,
    quad_segment_count:    3'd0,
    quad_segment_length:   3'd0,
    quad_segment_value:    10'd0,
    quad_leading_zero:     1'b0,
    quad_error:            1'b0,
    label_length:          7'd0,
    label_dots:            2'd0,
    prev_was_dot:          1'b0,
    prev_was_hyphen:       1'b0,
    first_was_dot:         1'b0,
    domain_error:          1'b0
  };

  function automatic logic [7:0] lh_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "l";
      4'd1:    c = "o";
      4'd2:    c = "c";
      4'd3:    c = "a";
      4'd4:    c = "l";
      4'd5:    c = "h";
      4'd6:    c = "o";
      4'd7:    c = "s";
      4'd8:    c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- design/hnsc_char_if.sv -----
// handshake channel carrying one host string byte per word
interface hnsc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       no_char;
  logic       last;

  modport source (output valid, output char_byte, output no_char, output last, input ready);
  modport sink   (input valid, input char_byte, input no_char, input last, output ready);
endinterface

// ----- design/hnsc_verdict_if.sv -----
// handshake channel carrying one host verdict per word
interface hnsc_verdict_if;
  logic       valid;
  logic       ready;
  logic       host_ok;
  logic [1:0] host_kind;

  modport source (output valid, output host_ok, output host_kind, input ready);
  modport sink   (input valid, input host_ok, input host_kind, output ready);
endinterface

// ----- design/hnsc_step.sv -----
// per-byte tracker update and end-of-host judgement
module hnsc_step
  import hnsc_pkg::*;
(
  input  hnsc_state_t cur,
  input  logic [7:0]  char_byte,
  input  logic        no_char,
  output hnsc_state_t nxt,
  output host_kind_t  kind
);

  logic       is_dot;
  logic       is_hyph;
  logic       is_dig;
  logic       is_alnum;
  logic       seg_bad;
  logic [2:0] seg_count_inc;
  logic       end_seg_bad;
  logic [2:0] end_count_inc;
  logic       fin_quad_error;
  logic [2:0] fin_quad_count;

  always_comb begin
    is_dot   = (char_byte == ".");
    is_hyph  = (char_byte == "-");
    is_dig   = (char_byte >= "0") && (char_byte <= "9");
    is_alnum = is_dig || ((char_byte >= "a") && (char_byte <= "z")) ||
               ((char_byte >= "A") && (char_byte <= "Z"));

    // segment close on a dot
    seg_bad = (cur.quad_segment_length == 3'd0) ||
              (cur.quad_segment_length > 3'(QUAD_MAX_DIGITS)) ||
              (cur.quad_leading_zero && (cur.quad_segment_length > 3'd1)) ||
              (cur.quad_segment_value > 10'(QUAD_MAX_VALUE));
    seg_count_inc = (cur.quad_segment_count < 3'(SEG_COUNT_MAX)) ?
                    cur.quad_segment_count + 3'd1 : cur.quad_segment_count;

    nxt = cur;
    if (!no_char) begin
      if (!cur.seen_any_char && is_dot) begin
        nxt.first_was_dot = 1'b1;
      end
      nxt.seen_any_char = 1'b1;

      if ((cur.localhost_match_pos < 4'(LH_LEN)) &&
          (char_byte == lh_char(cur.localhost_match_pos))) begin
        nxt.localhost_match_pos = cur.localhost_match_pos + 4'd1;
      end else begin
        nxt.localhost_mismatch = 1'b1;
      end

      if (is_hyph) begin
        nxt.has_hyphen = 1'b1;
      end else if (is_dot) begin
        nxt.quad_segment_count  = seg_count_inc;
        nxt.quad_error          = cur.quad_error || seg_bad ||
                                  (seg_count_inc > 3'(QUAD_SEGMENTS));
        nxt.quad_segment_length = 3'd0;
        nxt.quad_segment_value  = 10'd0;
        nxt.quad_leading_zero   = 1'b0;
      end else if (is_dig) begin
        if ((cur.quad_segment_length == 3'd0) && (char_byte == "0")) begin
          nxt.quad_leading_zero = 1'b1;
        end
        if (cur.quad_segment_length < 3'(QUAD_MAX_DIGITS)) begin
          nxt.quad_segment_value = 10'(cur.quad_segment_value * 10'd10) +
                                   10'(char_byte[3:0]);
        end
        if (cur.quad_segment_length < 3'(QUAD_MAX_DIGITS + 1)) begin
          nxt.quad_segment_length = cur.quad_segment_length + 3'd1;
        end
      end else begin
        nxt.only_digit_dot_hyphen = 1'b0;
      end

      if (is_dot) begin
        if ((cur.label_length == 7'd0) || cur.prev_was_hyphen) begin
          nxt.domain_error = 1'b1;
        end
        if (cur.label_dots < 2'(LABEL_COUNT_MAX)) begin
          nxt.label_dots = cur.label_dots + 2'd1;
        end
        nxt.label_length = 7'd0;
      end else if (is_hyph || is_alnum) begin
        if (is_hyph && (cur.label_length == 7'd0)) begin
          nxt.domain_error = 1'b1;
        end
        if (cur.label_length >= 7'(MAX_LABEL_LENGTH)) begin
          nxt.domain_error = 1'b1;
        end else begin
          nxt.label_length = cur.label_length + 7'd1;
        end
      end else begin
        nxt.domain_error = 1'b1;
      end

      nxt.prev_was_dot    = is_dot;
      nxt.prev_was_hyphen = is_hyph;
    end

    // closing the open segment at the end of the host
    end_seg_bad = (nxt.quad_segment_length == 3'd0) ||
                  (nxt.quad_segment_length > 3'(QUAD_MAX_DIGITS)) ||
                  (nxt.quad_leading_zero && (nxt.quad_segment_length > 3'd1)) ||
                  (nxt.quad_segment_value > 10'(QUAD_MAX_VALUE));
    end_count_inc = (nxt.quad_segment_count < 3'(SEG_COUNT_MAX)) ?
                    nxt.quad_segment_count + 3'd1 : nxt.quad_segment_count;
    if (nxt.prev_was_dot) begin
      fin_quad_error = nxt.quad_error;
      fin_quad_count = nxt.quad_segment_count;
    end else begin
      fin_quad_error = nxt.quad_error || end_seg_bad ||
                       (end_count_inc > 3'(QUAD_SEGMENTS));
      fin_quad_count = end_count_inc;
    end

    priority if (!nxt.seen_any_char) begin
      kind = KIND_REJECT;
    end else if (!nxt.localhost_mismatch &&
                 (nxt.localhost_match_pos == 4'(LH_LEN))) begin
      kind = KIND_LOCALHOST;
    end else if (nxt.only_digit_dot_hyphen) begin
      kind = (!nxt.has_hyphen && !fin_quad_error &&
              (fin_quad_count == 3'(QUAD_SEGMENTS))) ? KIND_QUAD : KIND_REJECT;
    end else if (nxt.first_was_dot || nxt.prev_was_dot || nxt.prev_was_hyphen ||
                 nxt.domain_error || (nxt.label_length == 7'd0)) begin
      kind = KIND_REJECT;
    end else begin
      kind = (nxt.label_dots >= 2'd1) ? KIND_DOMAIN : KIND_REJECT;
    end
  end

endmodule

// ----- design/host_name_syntax_check.sv -----
// host name syntax checker: byte stream in, one verdict word per host out
// path: the input byte register, the tracker update, then the registered verdict word
// throughput: one byte word per cycle unless the stall below holds input, set by the single tracker update stage
// a verdict word waiting at the output stalls input only when another last word
// is ready to finish; rst clears all tracker state and both valid flags
module host_name_syntax_check
  import hnsc_pkg::*;
(
  input logic           clk,
  input logic           rst,
  hnsc_char_if.sink     chars,
  hnsc_verdict_if.source verdict
);

  logic        s1_valid;
  logic [7:0]  s1_char_byte;
  logic        s1_no_char;
  logic        s1_last;
  logic        s1_adv;
  hnsc_state_t state;
  hnsc_state_t state_next;
  host_kind_t  step_kind;
  logic        out_valid;
  host_kind_t  out_kind;

  hnsc_step u_step (
    .cur       (state),
    .char_byte (s1_char_byte),
    .no_char   (s1_no_char),
    .nxt       (state_next),
    .kind      (step_kind)
  );

  assign s1_adv      = s1_valid && (!s1_last || !out_valid || verdict.ready);
  assign chars.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_INIT;
    end else begin
      if (chars.ready) begin
        s1_valid <= chars.valid;
      end
      if (s1_adv) begin
        state <= s1_last ? STATE_INIT : state_next;
      end
      if (s1_adv && s1_last) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char_byte <= chars.char_byte;
      s1_no_char   <= chars.no_char;
      s1_last      <= chars.last;
    end
    if (s1_adv && s1_last) begin
      out_kind <= step_kind;
    end
  end

  assign verdict.valid     = out_valid;
  assign verdict.host_ok   = (out_kind != KIND_REJECT);
  assign verdict.host_kind = out_kind;

endmodule
